[sv/u2e_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: shared types and constants
// Command word passed from the byte decoder to the unit sequencer, the
// result word, and the byte classification constants.
// ----------------------------------------------------------------------------
package u2e_pkg;

  // Command word: an optional decoded unit, then an optional string end or overflow.
  typedef struct packed {
    logic        has_unit;
    logic [15:0] unit;
    logic        fin;
    logic        ovf;
  } cmd_t;

  // Result word as it leaves the block.
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        ovf;
  } res_t;

  // Byte classification.
  localparam logic [7:0] AsciiMax  = 8'h7f;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Tag  = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Tag  = 8'he0;

  // Unit that replaces a complete entity.
  localparam logic [15:0] SpaceUnit = 16'h0020;

  // Characters of the entity "&#32;" in order.
  localparam logic [15:0] EntAmp   = 16'h0026;
  localparam logic [15:0] EntHash  = 16'h0023;
  localparam logic [15:0] EntThree = 16'h0033;
  localparam logic [15:0] EntTwo   = 16'h0032;
  localparam logic [15:0] EntSemi  = 16'h003b;

  // Returns the entity character at a given position.
  function automatic logic [15:0] entity_char(input logic [2:0] idx);
    logic [15:0] c;
    case (idx)
      3'd0:    c = EntAmp;
      3'd1:    c = EntHash;
      3'd2:    c = EntThree;
      3'd3:    c = EntTwo;
      3'd4:    c = EntSemi;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

[sv/u2e_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: byte decoder
// Accepts one byte per cycle while the queue has room, assembles 1-, 2- and
// 3-byte sequences, keeps the decode and byte counters and issues command words.
// ----------------------------------------------------------------------------
module u2e_front #(
  parameter int unsigned DECODE_LIMIT = 255,
  parameter int unsigned BYTE_BUDGET  = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          cmd_valid_o,
  output u2e_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import u2e_pkg::*;

  localparam int unsigned DecW = $clog2(DECODE_LIMIT + 1);
  localparam int unsigned BudW = $clog2(BYTE_BUDGET + 3);

  logic [1:0]      pend_q, pend_d;
  logic [15:0]     part_q, part_d;
  logic [DecW-1:0] dec_q, dec_d;
  logic [BudW-1:0] bud_q, bud_d;
  logic            done_q, done_d;

  logic accept;
  logic stop;
  logic have;
  logic fin;
  logic ovf_hit;
  logic [15:0] unit;
  cmd_t cmd;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign stop       = (in_byte_i == 8'h00) || in_last_i;

  // Decode one byte into the next state and a command word.
  always_comb begin
    pend_d  = pend_q;
    part_d  = part_q;
    dec_d   = dec_q;
    bud_d   = bud_q;
    done_d  = done_q;
    have    = 1'b0;
    fin     = 1'b0;
    ovf_hit = 1'b0;
    unit    = 16'h0000;
    cmd     = '0;

    if (done_q) begin
      // The string already ended; wait for its closing byte.
      if (stop) begin
        done_d = 1'b0;
      end
    end else begin
      if (in_byte_i == 8'h00) begin
        fin = 1'b1;
      end else if (pend_q != 2'd0) begin
        part_d = {part_q[9:0], in_byte_i[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          have = 1'b1;
          unit = part_d;
        end
      end else if (in_byte_i <= AsciiMax) begin
        have  = 1'b1;
        unit  = {8'h00, in_byte_i};
        bud_d = bud_q + BudW'(1);
      end else if ((in_byte_i & Lead2Mask) == Lead2Tag) begin
        part_d = {11'h000, in_byte_i[4:0]};
        pend_d = 2'd1;
        bud_d  = bud_q + BudW'(2);
      end else if ((in_byte_i & Lead3Mask) == Lead3Tag) begin
        part_d = {12'h000, in_byte_i[3:0]};
        pend_d = 2'd2;
        bud_d  = bud_q + BudW'(3);
      end

      // A finished unit counts toward the decode limit and is checked against the byte budget.
      if (have) begin
        dec_d = dec_q + DecW'(1);
        if (dec_d >= DecW'(DECODE_LIMIT)) begin
          ovf_hit = 1'b1;
        end else begin
          cmd.has_unit = 1'b1;
          cmd.unit     = unit;
          if (bud_d >= BudW'(BYTE_BUDGET)) begin
            fin = 1'b1;
          end
        end
      end
      if (in_last_i) begin
        fin = 1'b1;
      end

      cmd.ovf = ovf_hit;
      cmd.fin = fin && !ovf_hit;

      // End of the string: either wait for its close or start over.
      if (ovf_hit || fin) begin
        if (stop) begin
          pend_d = 2'd0;
          part_d = 16'h0000;
          dec_d  = '0;
          bud_d  = '0;
          done_d = 1'b0;
        end else begin
          done_d = 1'b1;
        end
      end
    end
  end

  // A clearing byte seen while waiting also resets the counters.
  logic clear_all;
  assign clear_all = done_q && stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= 16'h0000;
      dec_q  <= '0;
      bud_q  <= '0;
      done_q <= 1'b0;
    end else if (accept) begin
      if (clear_all) begin
        pend_q <= 2'd0;
        part_q <= 16'h0000;
        dec_q  <= '0;
        bud_q  <= '0;
      end else begin
        pend_q <= pend_d;
        part_q <= part_d;
        dec_q  <= dec_d;
        bud_q  <= bud_d;
      end
      done_q <= done_d;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept && (cmd.has_unit || cmd.fin || cmd.ovf);

endmodule

[sv/u2e_fifo.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: command queue
// Short first-in first-out queue of command words between the byte decoder
// and the unit sequencer.
// ----------------------------------------------------------------------------
module u2e_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  u2e_pkg::cmd_t push_data_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output u2e_pkg::cmd_t pop_data_o,
  input  logic          pop_ready_i
);
  import u2e_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Storage is written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[sv/u2e_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: unit sequencer
// Runs the entity match window, the output limit and the string end, one
// window step and at most one result word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module u2e_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  u2e_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  input  logic [7:0]    max_units_i,
  output logic          res_valid_o,
  output u2e_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import u2e_pkg::*;

  // Window entries, one more than the window holds while a unit is matched.
  logic [15:0] buf_q [5];
  logic [15:0] buf_s [5];
  logic [15:0] buf_d [5];
  logic [2:0]  len_q, len_s, len_d;
  logic        eval_q, eval_s, eval_d;
  logic        fin_q, fin_s, fin_d;
  logic        ovf_q, ovf_s, ovf_d;
  logic [7:0]  cnt_q, cnt_s;
  logic        closed_q, closed_s;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;

  logic        work, out_free, go;
  logic [4:0]  hit;
  logic        match5, pre_ok;
  logic        pass_req, term, term_ovf, emit;
  logic [15:0] pass_unit;
  res_t        res_n;

  assign work     = eval_q || fin_q || ovf_q;
  assign out_free = !out_valid_q || res_ready_i;
  assign go       = work && out_free;

  // Compare the window against the entity characters.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      hit[i] = (buf_q[i] == entity_char(3'(i)));
    end
    match5 = &hit;
    pre_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < len_q) && !hit[i]) begin
        pre_ok = 1'b0;
      end
    end
  end

  // One sequencer step.
  always_comb begin
    buf_s     = buf_q;
    len_s     = len_q;
    eval_s    = eval_q;
    fin_s     = fin_q;
    ovf_s     = ovf_q;
    pass_req  = 1'b0;
    pass_unit = 16'h0000;
    term      = 1'b0;
    term_ovf  = 1'b0;

    if (go) begin
      if (eval_q) begin
        if ((len_q == 3'd5) && match5) begin
          pass_req  = 1'b1;
          pass_unit = SpaceUnit;
          len_s     = 3'd0;
          eval_s    = 1'b0;
        end else if ((len_q != 3'd5) && pre_ok) begin
          eval_s = 1'b0;
        end else begin
          pass_req  = 1'b1;
          pass_unit = buf_q[0];
          for (int i = 0; i < 4; i++) begin
            buf_s[i] = buf_q[i+1];
          end
          buf_s[4] = 16'h0000;
          len_s    = len_q - 3'd1;
          if (len_q == 3'd1) begin
            eval_s = 1'b0;
          end
        end
      end else if (fin_q) begin
        // Flush the window, then close the string.
        if (len_q != 3'd0) begin
          pass_req  = 1'b1;
          pass_unit = buf_q[0];
          for (int i = 0; i < 4; i++) begin
            buf_s[i] = buf_q[i+1];
          end
          buf_s[4] = 16'h0000;
          len_s    = len_q - 3'd1;
        end else begin
          term  = 1'b1;
          fin_s = 1'b0;
        end
      end else begin
        // Overflow drops the window and closes the string.
        term     = 1'b1;
        term_ovf = 1'b1;
        ovf_s    = 1'b0;
        len_s    = 3'd0;
      end
    end
  end

  // Output limit, zero unit closing and the terminating word.
  always_comb begin
    emit     = 1'b0;
    cnt_s    = cnt_q;
    closed_s = closed_q;
    res_n    = '{unit: pass_unit, last: 1'b0, ovf: 1'b0};
    if (pass_req && !closed_q) begin
      if (pass_unit == 16'h0000) begin
        closed_s = 1'b1;
      end else if (cnt_q < max_units_i) begin
        emit  = 1'b1;
        cnt_s = cnt_q + 8'd1;
      end
    end
    if (term) begin
      emit     = 1'b1;
      res_n    = '{unit: 16'h0000, last: 1'b1, ovf: term_ovf};
      cnt_s    = 8'd0;
      closed_s = 1'b0;
    end
  end

  // Take the next command once the current one is done.
  assign cmd_ready_o = !(eval_s || fin_s || ovf_s);

  always_comb begin
    buf_d  = buf_s;
    len_d  = len_s;
    eval_d = eval_s;
    fin_d  = fin_s;
    ovf_d  = ovf_s;
    if (cmd_valid_i && cmd_ready_o) begin
      if (cmd_i.has_unit) begin
        for (int i = 0; i < 5; i++) begin
          if (len_s == 3'(i)) begin
            buf_d[i] = cmd_i.unit;
          end
        end
        len_d  = len_s + 3'd1;
        eval_d = 1'b1;
      end
      fin_d = cmd_i.fin;
      ovf_d = cmd_i.ovf;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit;
      out_d       = res_n;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 3'd0;
      eval_q      <= 1'b0;
      fin_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= 8'd0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      eval_q      <= eval_d;
      fin_q       <= fin_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_s;
      closed_q    <= closed_s;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[sv/utf8_to_ucs2_entity_filter_top.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: top level
// Decodes UTF-8 text into 16-bit code units and turns "&#32;" into a space.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one UTF-8 byte per word; tlast or a zero byte
//   ends a string. The output stream carries one code unit per word; each
//   string closes with a zero unit and tlast set, tuser set when the decode
//   limit was hit. cfg_we_i writes the most units passed on per string.
//   Throughput is one byte per cycle while the command queue has room; the
//   result sequencer sends one word per cycle while the output is not
//   stalled; a string end flushes the window before the terminator, and
//   a failed entity prefix releases its held units one word at a time.
//   A four-word command queue lets the input keep running while the
//   output is stalled; when it fills, s_axis_tready drops.
//   Reset empties the queue and the window, clears all counters and sets
//   the unit limit to 255.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_entity_filter_top #(
  parameter int unsigned DECODE_LIMIT = 255,
  parameter int unsigned BYTE_BUDGET  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_unit
  output logic        m_axis_tlast,   // out_last
  output logic [0:0]  m_axis_tuser,   // [0] overflow
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i     // max_out_units
);
  import u2e_pkg::*;

  logic [7:0] max_units_q;
  logic       f_valid, f_ready;
  cmd_t       f_cmd;
  logic       q_valid, q_ready;
  cmd_t       q_cmd;
  res_t       res;

  // Unit limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= 8'hff;
    end else if (cfg_we_i) begin
      max_units_q <= cfg_wdata_i;
    end
  end

  u2e_front #(
    .DECODE_LIMIT(DECODE_LIMIT),
    .BYTE_BUDGET (BYTE_BUDGET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_valid_o(f_valid),
    .cmd_o      (f_cmd),
    .cmd_ready_i(f_ready)
  );

  u2e_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_data_i (f_cmd),
    .push_ready_o(f_ready),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_cmd),
    .pop_ready_i (q_ready)
  );

  u2e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_ready_o(q_ready),
    .max_units_i(max_units_q),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata    = res.unit;
  assign m_axis_tlast    = res.last;
  assign m_axis_tuser[0] = res.ovf;

  // An overflow word is always a zero terminator.
  a_ovf_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == 16'h0000)))
    else $error("overflow flag on a word that is not a zero terminator");

  // A decoded zero unit never leaves the block as data.
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata != 16'h0000))
    else $error("zero code unit sent as data");

  // A stalled output word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

endmodule

[tb/u2e_tb_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: testbench scoreboard
// Predicts the code unit words that each accepted byte causes and checks the
// words that leave the block against them in order.
// ----------------------------------------------------------------------------
package u2e_tb_pkg;

  import u2e_pkg::*;

  // Block parameters as the testbench builds the block.
  localparam int unsigned DecodeLimit = 255;
  localparam int unsigned ByteBudget  = 255;

  // Emitted count that marks the output as closed for the rest of a string.
  localparam int ClosedMark = 256;

  // Only the first ten mismatches are printed.
  localparam int ReportMax = 10;

  class decode_scoreboard;

    // Result words still to arrive, oldest first.
    res_t units_due[$];

    // Shadow of the unit limit register and of the per-string state.
    logic [7:0]  unit_limit;
    logic [1:0]  cont_left;
    logic [15:0] code_acc;
    logic [15:0] held[4];
    int          held_len;
    int          decoded;
    int          emitted;
    int          lead_bytes;
    bit          ignore_rest;

    // Candidate window while a new unit is matched against the entity.
    logic [15:0] cand[5];
    int          cand_len;

    // Run statistics.
    int mismatches;
    int words_checked;
    int strings_ended;
    int overflow_ends;

    function new();
      unit_limit    = 8'd255;
      mismatches    = 0;
      words_checked = 0;
      strings_ended = 0;
      overflow_ends = 0;
      clear_string();
    endfunction

    function void clear_string();
      cont_left   = 2'd0;
      code_acc    = 16'h0000;
      for (int i = 0; i < 4; i++) held[i] = 16'h0000;
      held_len    = 0;
      decoded     = 0;
      emitted     = 0;
      lead_bytes  = 0;
      ignore_rest = 1'b0;
    endfunction

    function void expect_word(logic [15:0] unit, logic last, logic ovf);
      res_t w;
      w.unit = unit;
      w.last = last;
      w.ovf  = ovf;
      units_due.push_back(w);
      if (last) strings_ended++;
      if (ovf) overflow_ends++;
    endfunction

    // A zero unit closes the output; units past the limit are dropped.
    function void emit_unit(logic [15:0] unit);
      if (emitted >= ClosedMark) return;
      if (unit == 16'h0000) begin
        emitted = ClosedMark;
        return;
      end
      if (emitted < int'(unit_limit)) begin
        expect_word(unit, 1'b0, 1'b0);
        emitted++;
      end
    endfunction

    function bit cand_is_prefix();
      bit ok;
      ok = 1'b1;
      if (cand_len > 0 && cand[0] != EntAmp) ok = 1'b0;
      if (cand_len > 1 && cand[1] != EntHash) ok = 1'b0;
      if (cand_len > 2 && cand[2] != EntThree) ok = 1'b0;
      if (cand_len > 3 && cand[3] != EntTwo) ok = 1'b0;
      if (cand_len > 4 && cand[4] != EntSemi) ok = 1'b0;
      return ok;
    endfunction

    // Appends a unit to the held units and releases whatever can no longer
    // be part of an entity; a complete entity becomes one space.
    function void feed_unit(logic [15:0] unit);
      for (int i = 0; i < held_len; i++) cand[i] = held[i];
      cand[held_len] = unit;
      cand_len = held_len + 1;
      while (cand_len > 0) begin
        if (cand_len == 5 && cand_is_prefix()) begin
          emit_unit(SpaceUnit);
          cand_len = 0;
        end else if (cand_len < 5 && cand_is_prefix()) begin
          break;
        end else begin
          emit_unit(cand[0]);
          for (int i = 1; i < cand_len; i++) cand[i-1] = cand[i];
          cand_len--;
        end
      end
      for (int i = 0; i < 4; i++) held[i] = (i < cand_len) ? cand[i] : 16'h0000;
      held_len = cand_len;
    endfunction

    function void flush_held();
      for (int i = 0; i < held_len; i++) emit_unit(held[i]);
      for (int i = 0; i < 4; i++) held[i] = 16'h0000;
      held_len = 0;
    endfunction

    // Notes one accepted byte and queues the words it causes.
    function void take_byte(logic [7:0] data, logic last);
      bit          stop;
      bit          have;
      bit          finish;
      logic [15:0] unit;
      stop   = (data == 8'h00) || last;
      have   = 1'b0;
      finish = 1'b0;
      unit   = 16'h0000;

      // After an early end the rest of the string is skipped.
      if (ignore_rest) begin
        if (stop) clear_string();
        return;
      end

      // Byte decode: continuation, ASCII, 2-byte lead, 3-byte lead.
      if (data == 8'h00) begin
        finish = 1'b1;
      end else if (cont_left != 2'd0) begin
        code_acc = {code_acc[9:0], data[5:0]};
        cont_left--;
        if (cont_left == 2'd0) begin
          have = 1'b1;
          unit = code_acc;
        end
      end else if (data <= AsciiMax) begin
        have = 1'b1;
        unit = {8'h00, data};
        lead_bytes += 1;
      end else if ((data & Lead2Mask) == Lead2Tag) begin
        code_acc  = {11'h000, data[4:0]};
        cont_left = 2'd1;
        lead_bytes += 2;
      end else if ((data & Lead3Mask) == Lead3Tag) begin
        code_acc  = {12'h000, data[3:0]};
        cont_left = 2'd2;
        lead_bytes += 3;
      end

      // A decoded unit either hits the decode limit or goes to the window.
      if (have) begin
        decoded++;
        if (decoded >= int'(DecodeLimit)) begin
          expect_word(16'h0000, 1'b1, 1'b1);
          if (stop) clear_string();
          else ignore_rest = 1'b1;
          return;
        end
        feed_unit(unit);
        if (lead_bytes >= int'(ByteBudget)) finish = 1'b1;
      end
      if (last) finish = 1'b1;

      // String end: release held units, then the terminator.
      if (finish) begin
        flush_held();
        expect_word(16'h0000, 1'b1, 1'b0);
        if (stop) clear_string();
        else ignore_rest = 1'b1;
      end
    endfunction

    // Compares one result word with the oldest expected word.
    function void check_unit(res_t got);
      res_t want;
      words_checked++;
      if (units_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("ERROR: word unit %h last %b ovf %b arrived with none expected",
                   got.unit, got.last, got.ovf);
        return;
      end
      want = units_due.pop_front();
      if (got.unit !== want.unit || got.last !== want.last || got.ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("ERROR: word %0d expected unit %h last %b ovf %b, got unit %h last %b ovf %b",
                   words_checked, want.unit, want.last, want.ovf,
                   got.unit, got.last, got.ovf);
      end
    endfunction

  endclass

endpackage

[tb/utf8_to_ucs2_entity_filter_top_tb.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 entity filter: top-level testbench
// Drives UTF-8 strings through the input stream with random gaps and output
// stalls, predicts every code unit word and checks the output stream in order
// under several unit limit settings, including a long output hold-off.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_entity_filter_top_tb;

  import u2e_pkg::*;
  import u2e_tb_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 80;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] out_unit
  logic        m_axis_tlast;           // out_last
  logic [0:0]  m_axis_tuser;           // [0] overflow
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_off    = 1'b0;
  logic pressure_go = 1'b0;
  int   cycle_count = 0;
  int   bytes_sent  = 0;

  logic [7:0] pending_seq[$];
  decode_scoreboard sb;

  utf8_to_ucs2_entity_filter_top #(
    .DECODE_LIMIT(DecodeLimit),
    .BYTE_BUDGET (ByteBudget)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a forced hold-off while pressure is on.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Output words are sampled mid-cycle, where they are stable up to the edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_unit(res_t'({m_axis_tdata, m_axis_tlast, m_axis_tuser}));
  end

  // Long receiver hold-off, timed in its own process.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Offers one byte and returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] data, input logic last);
    logic took;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    sb.take_byte(data, last);
    bytes_sent++;
  endtask

  // Sends the queued bytes, optionally with tlast on the final one.
  task automatic send_seq(input bit mark_last);
    for (int i = 0; i < pending_seq.size(); i++)
      send_byte(pending_seq[i], mark_last && (i == pending_seq.size() - 1));
    pending_seq.delete();
  endtask

  // Mostly well-formed text: ASCII, 2- and 3-byte sequences, entities and
  // entity prefixes, with some skipped leads and raw bytes mixed in.
  task automatic send_random_string(input int max_units);
    int n_units;
    int pick;
    int cut;
    n_units = $urandom_range(0, max_units);
    for (int u = 0; u < n_units; u++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        pending_seq.push_back(8'($urandom_range(1, 127)));
      end else if (pick < 50) begin
        pending_seq.push_back(8'hc0 | 8'($urandom_range(0, 31)));
        pending_seq.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 65) begin
        pending_seq.push_back(8'he0 | 8'($urandom_range(0, 15)));
        pending_seq.push_back(8'($urandom_range(1, 255)));
        pending_seq.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 90) begin
        cut = (pick < 78) ? 5 : $urandom_range(1, 4);
        pending_seq.push_back(8'h26);
        if (cut > 1) pending_seq.push_back(8'h23);
        if (cut > 2) pending_seq.push_back(8'h33);
        if (cut > 3) pending_seq.push_back(8'h32);
        if (cut > 4) pending_seq.push_back(8'h3b);
      end else if (pick < 95) begin
        pending_seq.push_back(8'($urandom_range(0, 1) ? $urandom_range(128, 191)
                                                      : $urandom_range(240, 255)));
      end else begin
        pending_seq.push_back(8'($urandom_range(1, 255)));
      end
    end
    // End either with a zero byte or with tlast on the final byte.
    if (pending_seq.size() == 0 || $urandom_range(0, 1)) begin
      pending_seq.push_back(8'h00);
      send_seq(1'($urandom_range(0, 1)));
    end else begin
      send_seq(1'b1);
    end
  endtask

  // Raw bytes over the whole range, then a clean string end.
  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic random_traffic(input int n_bytes, input int max_units);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(2, 8));
      else send_random_string(max_units);
    end
  endtask

  // Waits until every expected word has arrived and the block has settled.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.units_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_unit_limit(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.unit_limit = value;
  endtask

  // Main sequence.
  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_unit_limit(8'd255);

    // Sender mostly busy, receiver mostly stalled.
    tx_idle_pct = 8;
    rx_idle_pct <= 62;

    // Directed: every byte class, an entity, tlast on a completing unit.
    pending_seq = '{8'h41, 8'hc3, 8'ha9, 8'hef, 8'hbf, 8'hbf, 8'h80, 8'hf0,
                    8'hff, 8'h26, 8'h23, 8'h33, 8'h32, 8'h3b, 8'h7f};
    send_seq(1'b1);
    // Held entity prefix, decoded zero unit closing the output, and a zero
    // byte cutting a 3-byte sequence short.
    pending_seq = '{8'h26, 8'h23, 8'h33, 8'hc0, 8'h80, 8'h42, 8'he2, 8'h00};
    send_seq(1'b0);
    // Entity prefix released by the string end.
    pending_seq = '{8'h26, 8'h23};
    send_seq(1'b1);

    random_traffic(50, 10);
    drain_results();

    // Truncation settings with the idling swapped.
    set_unit_limit(8'd4);
    tx_idle_pct = 62;
    rx_idle_pct <= 8;
    random_traffic(35, 10);
    drain_results();
    set_unit_limit(8'd0);
    random_traffic(10, 6);
    drain_results();
    set_unit_limit(8'd1);
    random_traffic(10, 6);
    drain_results();

    // No idling; the receiver holds off for a while so the input backs up.
    set_unit_limit(8'd255);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    pressure_go <= 1'b1;
    random_traffic(30, 12);
    drain_results();

    $display("Run covered %0d input bytes in %0d strings with random gaps and a long stall.",
             bytes_sent, sb.strings_ended);
    $display("Checked %0d output words under unit limits 255, 4, 0 and 1; %0d mismatches.",
             sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.units_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
